// File: rtl/core/abcp_pkg.sv
// ----------------------------------------------------------------------------
// abcp_pkg
// Types and character constants shared by the angle-bracket command parser.
// ----------------------------------------------------------------------------
`default_nettype none

package abcp_pkg;

    localparam int VALUE_W    = 64;
    localparam int OUT_VALUES = 4;

    // ASCII characters of the frame syntax
    localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
    localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
    localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
    localparam logic [7:0] CH_L     = 8'h4C;  // 'L'
    localparam logic [7:0] CH_S     = 8'h53;  // 'S'
    localparam logic [7:0] CH_R     = 8'h52;  // 'R'
    localparam logic [7:0] CH_D     = 8'h44;  // 'D'
    localparam logic [7:0] CH_X     = 8'h78;  // 'x'
    localparam logic [7:0] CH_0     = 8'h30;  // '0'
    localparam logic [7:0] CH_9     = 8'h39;  // '9'
    localparam logic [7:0] CH_A     = 8'h41;  // 'A'
    localparam logic [7:0] CH_F     = 8'h46;  // 'F'

    // subcommand codes
    localparam logic [2:0] SUB_SEND    = 3'd0;
    localparam logic [2:0] SUB_LISTENS = 3'd1;
    localparam logic [2:0] SUB_SENDS   = 3'd2;
    localparam logic [2:0] SUB_READY   = 3'd3;
    localparam logic [2:0] SUB_DUMP    = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_OP1,
        PH_OP2,
        PH_GAP,
        PH_NUM
    } phase_t;

    typedef struct packed {
        logic       is_lt;
        logic       is_gt;
        logic       is_space;
        logic       is_x;
        logic       is_l;
        logic       sub_ok;
        logic [2:0] sub_code;
        logic       digit_ok;
        logic [3:0] digit;
    } char_class_t;

    typedef struct packed {
        logic       clear;
        logic       start;
        logic       acc;
        logic       hex;
        logic       is_x;
        logic       digit_ok;
        logic [3:0] digit;
    } lane_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/abcp_if.sv
// ----------------------------------------------------------------------------
// abcp_if
// Valid/ready channels of the parser: received characters and parsed frames.
// ----------------------------------------------------------------------------
`default_nettype none

interface abcp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface abcp_frame_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command_code;
    logic [2:0]  value_count;
    logic [63:0] value_first;
    logic [63:0] value_second;
    logic [63:0] value_third;
    logic [63:0] value_fourth;

    modport source (output valid, output command_code, output value_count,
                    output value_first, output value_second, output value_third,
                    output value_fourth, input ready);
    modport sink   (input valid, input command_code, input value_count,
                    input value_first, input value_second, input value_third,
                    input value_fourth, output ready);
endinterface

`default_nettype wire

// File: rtl/core/abcp_char_decode.sv
// ----------------------------------------------------------------------------
// abcp_char_decode
// Classifies one received character: delimiters, subcommands, digit value.
// ----------------------------------------------------------------------------
`default_nettype none

module abcp_char_decode (
    input  logic [7:0]                ch,
    output abcp_pkg::char_class_t     cls
);
    import abcp_pkg::*;

    logic [7:0] dec_diff;
    logic [7:0] hex_diff;

    assign dec_diff = ch - CH_0;
    assign hex_diff = ch - CH_A + 8'd10;

    always_comb
    begin
        cls          = '0;
        cls.is_lt    = (ch == CH_LT);
        cls.is_gt    = (ch == CH_GT);
        cls.is_space = (ch == CH_SPACE);
        cls.is_x     = (ch == CH_X);
        cls.is_l     = (ch == CH_L);

        cls.sub_ok = 1'b1;
        unique case (ch)
            CH_SPACE: cls.sub_code = SUB_SEND;
            CH_L:     cls.sub_code = SUB_LISTENS;
            CH_S:     cls.sub_code = SUB_SENDS;
            CH_R:     cls.sub_code = SUB_READY;
            CH_D:     cls.sub_code = SUB_DUMP;
            default:
            begin
                cls.sub_ok   = 1'b0;
                cls.sub_code = SUB_SEND;
            end
        endcase

        // letters A-F count as digits 10-15 in either base
        if (ch >= CH_0 && ch <= CH_9)
        begin
            cls.digit_ok = 1'b1;
            cls.digit    = dec_diff[3:0];
        end
        else if (ch >= CH_A && ch <= CH_F)
        begin
            cls.digit_ok = 1'b1;
            cls.digit    = hex_diff[3:0];
        end
        else
        begin
            cls.digit_ok = 1'b0;
            cls.digit    = 4'd0;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/abcp_value_lane.sv
// ----------------------------------------------------------------------------
// abcp_value_lane
// One numeric value register with clear, start and base-10/16 accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

module abcp_value_lane (
    input  logic                       clk,
    input  abcp_pkg::lane_ctl_t        ctl,
    output logic [abcp_pkg::VALUE_W-1:0] value
);
    import abcp_pkg::*;

    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic [VALUE_W-1:0] scaled;

    // x*10 = x*8 + x*2, x*16 = shift; wraps modulo 2^64
    assign scaled = ctl.hex ? (value_reg << 4) : ((value_reg << 3) + (value_reg << 1));

    always_comb
    begin
        value_next = value_reg;
        if (ctl.clear)
        begin
            value_next = '0;
        end
        else if (ctl.start)
        begin
            // 'x' only selects hex; any other first char means decimal, loaded if a digit
            value_next = (!ctl.is_x && ctl.digit_ok) ? VALUE_W'(ctl.digit) : '0;
        end
        else if (ctl.acc && ctl.digit_ok)
        begin
            value_next = scaled + VALUE_W'(ctl.digit);
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// File: rtl/core/angle_bracket_command_parser.sv
// ----------------------------------------------------------------------------
// angle_bracket_command_parser
// Recognizes '<L' frames in a character stream and reports the subcommand
// and up to four numeric values for each completed frame.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while chars.ready is high; each character
//   is fully handled in the cycle it is accepted (one 64-bit multiply-by-constant add per lane).
// Output: a frame is on the output register in the cycle after its '>' is accepted.
// chars.ready drops only while a finished frame waits and frames.ready is low.
// Reset: parser waits for '<', count and subcommand cleared, no frame pending.
// ----------------------------------------------------------------------------
`default_nettype none

module angle_bracket_command_parser #(
    parameter int MAX_VALUES = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    abcp_char_if.sink           chars,
    abcp_frame_if.source        frames
);
    import abcp_pkg::*;

    localparam int CNT_W = $clog2(MAX_VALUES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VALUES);

    phase_t             phase_reg, phase_next;
    logic [2:0]         sub_reg, sub_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               hex_reg, hex_next;
    logic               out_valid_reg, out_valid_next;

    logic [2:0]         res_cmd_reg;
    logic [2:0]         res_count_reg;
    logic [VALUE_W-1:0] res_value_reg [OUT_VALUES];
    logic [VALUE_W-1:0] res_value_next [OUT_VALUES];
    logic [3:0]         count_wide;
    logic [2:0]         count_sat;

    logic               accept;
    logic               clear_all;
    logic               start_value;
    logic               acc_value;
    logic               emit;
    char_class_t        cls;
    logic [VALUE_W-1:0] lane_value [MAX_VALUES];

    assign chars.ready = !out_valid_reg || frames.ready;
    assign accept      = chars.valid && chars.ready;

    abcp_char_decode u_decode (
        .ch  (chars.byte_in),
        .cls (cls)
    );

    // ---------------- frame state machine ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            sub_reg       <= SUB_SEND;
            count_reg     <= '0;
            hex_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            sub_reg       <= sub_next;
            count_reg     <= count_next;
            hex_reg       <= hex_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        sub_next    = sub_reg;
        count_next  = count_reg;
        hex_next    = hex_reg;
        clear_all   = 1'b0;
        start_value = 1'b0;
        acc_value   = 1'b0;
        emit        = 1'b0;

        if (accept)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (cls.is_lt)
                    begin
                        phase_next = PH_OP1;
                    end
                end
                PH_OP1:
                begin
                    phase_next = cls.is_l ? PH_OP2 : PH_IDLE;
                end
                PH_OP2:
                begin
                    if (cls.sub_ok)
                    begin
                        sub_next   = cls.sub_code;
                        count_next = '0;
                        clear_all  = 1'b1;
                        phase_next = PH_GAP;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_GAP:
                begin
                    priority if (cls.is_space)
                    begin
                        phase_next = PH_GAP;
                    end
                    else if (cls.is_gt)
                    begin
                        emit       = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        start_value = 1'b1;
                        hex_next    = cls.is_x;
                        phase_next  = PH_NUM;
                    end
                end
                PH_NUM:
                begin
                    priority if (cls.is_space || cls.is_gt)
                    begin
                        if (count_reg < MAX_CNT)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        emit       = cls.is_gt;
                        phase_next = cls.is_gt ? PH_IDLE : PH_GAP;
                    end
                    else
                    begin
                        acc_value = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // ---------------- value lanes ----------------
    for (genvar k = 0; k < MAX_VALUES; k++)
    begin : g_lane
        lane_ctl_t ctl;

        always_comb
        begin
            ctl.clear    = clear_all;
            ctl.start    = start_value && (count_reg == CNT_W'(k));
            ctl.acc      = acc_value && (count_reg == CNT_W'(k));
            ctl.hex      = hex_reg;
            ctl.is_x     = cls.is_x;
            ctl.digit_ok = cls.digit_ok;
            ctl.digit    = cls.digit;
        end

        abcp_value_lane u_lane (
            .clk   (clk),
            .ctl   (ctl),
            .value (lane_value[k])
        );
    end

    // ---------------- result register ----------------
    for (genvar k = 0; k < OUT_VALUES; k++)
    begin : g_res
        if (k < MAX_VALUES)
        begin : g_live
            assign res_value_next[k] = (count_next > CNT_W'(k)) ? lane_value[k] : '0;
        end
        else
        begin : g_absent
            assign res_value_next[k] = '0;
        end
    end

    assign count_wide = 4'(count_next);
    assign count_sat  = (count_wide > 4'd4) ? 3'd4 : count_wide[2:0];

    assign out_valid_next = emit ? 1'b1 : (frames.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_cmd_reg   <= sub_reg;
            res_count_reg <= count_sat;
            for (int i = 0; i < OUT_VALUES; i++)
            begin
                res_value_reg[i] <= res_value_next[i];
            end
        end
    end

    assign frames.valid        = out_valid_reg;
    assign frames.command_code = res_cmd_reg;
    assign frames.value_count  = res_count_reg;
    assign frames.value_first  = res_value_reg[0];
    assign frames.value_second = res_value_reg[1];
    assign frames.value_third  = res_value_reg[2];
    assign frames.value_fourth = res_value_reg[3];

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("value count above limit");

    a_gt_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cls.is_gt && (phase_reg == PH_GAP || phase_reg == PH_NUM))
        |=> (out_valid_reg && phase_reg == PH_IDLE))
        else $error("closing bracket did not produce a frame");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !frames.ready) |-> !chars.ready)
        else $error("input taken while a frame is stalled");

    a_emit_phase: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (phase_reg == PH_GAP || phase_reg == PH_NUM))
        else $error("frame emitted outside a frame body");

    a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_count_reg == 3'd0) |-> (res_value_reg[0] == '0))
        else $error("absent value not zero");

endmodule

`default_nettype wire

// File: tb/abcp_frame_checker.sv
// ----------------------------------------------------------------------------
// abcp_frame_checker
// Watches the character and frame channels, tracks the frame syntax on every
// accepted character and compares each emitted frame against its prediction.
// ----------------------------------------------------------------------------
module abcp_frame_checker #(
    parameter int MAX_VALUES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    input  logic        char_ready,
    input  logic [7:0]  char_byte,
    input  logic        frame_valid,
    input  logic        frame_ready,
    input  logic [2:0]  command_code,
    input  logic [2:0]  value_count,
    input  logic [63:0] value_first,
    input  logic [63:0] value_second,
    input  logic [63:0] value_third,
    input  logic [63:0] value_fourth,
    output int          errors,
    output int          pending,
    output int          frames_checked
);
    import abcp_pkg::*;

    typedef struct packed {
        logic [2:0]  code;
        logic [2:0]  count;
        logic [63:0] v_first;
        logic [63:0] v_second;
        logic [63:0] v_third;
        logic [63:0] v_fourth;
    } frame_rec_t;

    phase_t      parse_phase;
    logic [2:0]  sub_code;
    int          value_idx;
    logic        hex_sel;
    logic [63:0] acc_value [MAX_VALUES];
    frame_rec_t  expected_frames [$];
    frame_rec_t  want;

    task automatic add_digit(input logic [7:0] c);
        logic [3:0] d;
        logic       ok;
        ok = 1'b1;
        d  = '0;
        if (c >= CH_0 && c <= CH_9)
            d = 4'(c - CH_0);
        else if (c >= CH_A && c <= CH_F)
            d = 4'(c - CH_A + 8'd10);
        else
            ok = 1'b0;
        // letters count in decimal too; product wraps at 64 bits
        if (ok && value_idx < MAX_VALUES)
            acc_value[value_idx] = acc_value[value_idx] * (hex_sel ? 64'd16 : 64'd10)
                                   + 64'(d);
    endtask

    task automatic close_value();
        if (value_idx < MAX_VALUES)
            value_idx++;
    endtask

    task automatic queue_frame();
        logic [63:0] v [4];
        frame_rec_t  rec;
        for (int k = 0; k < 4; k++)
            v[k] = (k < value_idx && k < MAX_VALUES) ? acc_value[k] : '0;
        rec.code     = sub_code;
        rec.count    = 3'(value_idx > 4 ? 4 : value_idx);
        rec.v_first  = v[0];
        rec.v_second = v[1];
        rec.v_third  = v[2];
        rec.v_fourth = v[3];
        expected_frames.push_back(rec);
        parse_phase = PH_IDLE;
    endtask

    task automatic predict_char(input logic [7:0] c);
        logic sub_ok;
        sub_ok = 1'b1;
        case (parse_phase)
            PH_IDLE:
                if (c == CH_LT)
                    parse_phase = PH_OP1;
            PH_OP1:
                parse_phase = (c == CH_L) ? PH_OP2 : PH_IDLE;
            PH_OP2:
            begin
                case (c)
                    CH_SPACE: sub_code = SUB_SEND;
                    CH_L:     sub_code = SUB_LISTENS;
                    CH_S:     sub_code = SUB_SENDS;
                    CH_R:     sub_code = SUB_READY;
                    CH_D:     sub_code = SUB_DUMP;
                    default:  sub_ok = 1'b0;
                endcase
                if (sub_ok)
                begin
                    value_idx = 0;
                    for (int k = 0; k < MAX_VALUES; k++)
                        acc_value[k] = '0;
                    parse_phase = PH_GAP;
                end
                else
                    parse_phase = PH_IDLE;
            end
            PH_GAP:
            begin
                if (c == CH_GT)
                    queue_frame();
                else if (c != CH_SPACE)
                begin
                    // first char of a value: clear it, 'x' picks hex and is eaten
                    if (value_idx < MAX_VALUES)
                        acc_value[value_idx] = '0;
                    parse_phase = PH_NUM;
                    hex_sel = (c == CH_X);
                    if (!hex_sel)
                        add_digit(c);
                end
            end
            PH_NUM:
            begin
                if (c == CH_SPACE)
                begin
                    close_value();
                    parse_phase = PH_GAP;
                end
                else if (c == CH_GT)
                begin
                    close_value();
                    queue_frame();
                end
                else
                    add_digit(c);
            end
            default:
                parse_phase = PH_IDLE;
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_phase = PH_IDLE;
            sub_code    = SUB_SEND;
            value_idx   = 0;
            hex_sel     = 1'b0;
            for (int k = 0; k < MAX_VALUES; k++)
                acc_value[k] = '0;
            expected_frames.delete();
            pending = 0;
        end
        else
        begin
            if (char_valid && char_ready)
                predict_char(char_byte);
            if (frame_valid && frame_ready)
            begin
                if (expected_frames.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected frame: expected none, actual code %0d count %0d",
                             $time, command_code, value_count);
                end
                else
                begin
                    want = expected_frames.pop_front();
                    check_field("command_code", 64'(want.code), 64'(command_code));
                    check_field("value_count", 64'(want.count), 64'(value_count));
                    check_field("value_first", want.v_first, value_first);
                    check_field("value_second", want.v_second, value_second);
                    check_field("value_third", want.v_third, value_third);
                    check_field("value_fourth", want.v_fourth, value_fourth);
                    frames_checked++;
                end
            end
            pending = expected_frames.size();
        end
    end

endmodule

// File: tb/angle_bracket_command_parser_tb.sv
// ----------------------------------------------------------------------------
// angle_bracket_command_parser_tb
// Drives character streams (directed frames, then random well-formed frames,
// broken frames and line noise) under bursty input and a stalling receiver;
// the frame checker predicts and compares every emitted frame.
// ----------------------------------------------------------------------------
module angle_bracket_command_parser_tb;
    import abcp_pkg::*;

    localparam int HALF_PERIOD      = 10;
    localparam int RESET_CYCLES     = 7;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int HOLD_CYCLES      = 400;
    localparam int N_PHASES         = 4;
    localparam int CHARS_PER_PHASE  = 150;
    localparam int TAIL_CYCLES      = 10;

    logic clk = 1'b0;
    logic rst_n;

    always #HALF_PERIOD clk = ~clk;

    abcp_char_if  chars_if ();
    abcp_frame_if frames_if ();

    int errors;
    int pending;
    int frames_checked;
    int sent_items     = 0;
    int directed_items = 0;
    int burst_left     = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int cycle_count    = 0;

    logic [7:0] tx_bytes [$];

    angle_bracket_command_parser #(.MAX_VALUES(4)) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .frames (frames_if)
    );

    abcp_frame_checker #(.MAX_VALUES(4)) frame_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .char_valid     (chars_if.valid),
        .char_ready     (chars_if.ready),
        .char_byte      (chars_if.byte_in),
        .frame_valid    (frames_if.valid),
        .frame_ready    (frames_if.ready),
        .command_code   (frames_if.command_code),
        .value_count    (frames_if.value_count),
        .value_first    (frames_if.value_first),
        .value_second   (frames_if.value_second),
        .value_third    (frames_if.value_third),
        .value_fourth   (frames_if.value_fourth),
        .errors         (errors),
        .pending        (pending),
        .frames_checked (frames_checked)
    );

    // one transaction per call; entered and left on a falling edge
    task automatic send_char(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                chars_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        chars_if.valid   <= 1'b1;
        chars_if.byte_in <= b;
        do
            @(posedge clk);
        while (!chars_if.ready);
        @(negedge clk);
        burst_left--;
        sent_items++;
    endtask

    task automatic send_queued();
        while (tx_bytes.size() != 0)
            send_char(tx_bytes.pop_front());
    endtask

    task automatic drain_frames();
        chars_if.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            tx_bytes.push_back(s[i]);
    endtask

    // char inside a number: mostly digits, some letters, rare junk
    function automatic logic [7:0] value_char(input logic hex);
        logic [7:0] c;
        int         r;
        int         v;
        r = $urandom_range(0, 15);
        if (r == 0)
        begin
            do
                c = 8'($urandom_range(0, 255));
            while (c == CH_SPACE || c == CH_GT);
        end
        else
        begin
            v = (hex || r == 1) ? $urandom_range(0, 15) : $urandom_range(0, 9);
            c = (v < 10) ? CH_0 + 8'(v) : CH_A + 8'(v - 10);
        end
        return c;
    endfunction

    task automatic build_sequence();
        logic [7:0] sub_chars [5];
        logic [7:0] c;
        int         kind;
        int         nvals;
        int         ndig;
        logic       hex;
        sub_chars = '{CH_SPACE, CH_L, CH_S, CH_R, CH_D};
        kind = $urandom_range(0, 99);
        if (kind < 80)
        begin
            tx_bytes.push_back(CH_LT);
            tx_bytes.push_back(CH_L);
            tx_bytes.push_back(sub_chars[$urandom_range(0, 4)]);
            nvals = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
            for (int i = 0; i < nvals; i++)
            begin
                repeat ($urandom_range(i == 0 ? 0 : 1, 3))
                    tx_bytes.push_back(CH_SPACE);
                hex = 1'($urandom_range(0, 1));
                if (hex)
                begin
                    tx_bytes.push_back(CH_X);
                    ndig = $urandom_range(0, 17);
                end
                else
                    ndig = $urandom_range(1, 21);
                repeat (ndig)
                    tx_bytes.push_back(value_char(hex));
            end
            repeat ($urandom_range(0, 2))
                tx_bytes.push_back(CH_SPACE);
            tx_bytes.push_back(CH_GT);
        end
        else if (kind < 90)
        begin
            tx_bytes.push_back(CH_LT);
            case ($urandom_range(0, 2))
                0:
                begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (c == CH_L);
                    tx_bytes.push_back(c);
                end
                1:
                begin
                    tx_bytes.push_back(CH_L);
                    do
                        c = 8'($urandom_range(0, 255));
                    while (c == CH_SPACE || c == CH_L || c == CH_S || c == CH_R || c == CH_D);
                    tx_bytes.push_back(c);
                end
                default:
                begin
                    // frame cut short: the following characters land in its value
                    tx_bytes.push_back(CH_L);
                    tx_bytes.push_back(sub_chars[$urandom_range(0, 4)]);
                    repeat ($urandom_range(1, 5))
                        tx_bytes.push_back(value_char(1'b0));
                end
            endcase
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                tx_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // receiver: changing stall patterns, plus long hold-offs on request
    initial
    begin
        int mode;
        int mode_left;
        frames_if.ready = 1'b0;
        mode      = 0;
        mode_left = 0;
        forever
        begin
            @(negedge clk);
            if (holds_served != hold_requests)
            begin
                frames_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                holds_served++;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(30, 150);
                end
                mode_left--;
                case (mode)
                    0:       frames_if.ready <= 1'b1;
                    1:       frames_if.ready <= ($urandom_range(0, 3) != 0);
                    2:       frames_if.ready <= ($urandom_range(0, 3) == 0);
                    default: frames_if.ready <= ((mode_left % 8) < 4);
                endcase
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d frames outstanding", cycle_count, pending);
        $display("angle_bracket_command_parser test failed");
        $finish;
    end

    initial
    begin
        int phase_start;
        chars_if.valid   = 1'b0;
        chars_if.byte_in = 8'h00;
        rst_n            = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // stray bytes, abandoned starts, all subcommands, wrap, saturation
        tx_bytes.push_back(8'h00);
        tx_bytes.push_back(8'hFF);
        tx_bytes.push_back(CH_GT);
        push_str("<X<LQ<LR>");
        push_str("<L 7 xA9 AF 12 99 5>");
        push_str("<LLx1FFFFFFFFFFFFFFFF 18446744073709551616>");
        push_str("<LS12 >");
        push_str("<LDx>");
        push_str("<LR7q8 x>");
        send_queued();
        directed_items = sent_items;
        drain_frames();

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph == 1 || ph == 3)
                hold_requests++;
            phase_start = sent_items;
            while (sent_items - phase_start < CHARS_PER_PHASE)
            begin
                build_sequence();
                send_queued();
            end
            drain_frames();
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        $display("sent %0d characters (%0d directed), checked %0d frames, %0d receiver hold-offs",
                 sent_items, directed_items, frames_checked, holds_served);
        if (pending != 0)
            $display("%0t: %0d expected frames never arrived", $time, pending);
        if (errors == 0 && pending == 0)
            $display("angle_bracket_command_parser test passed");
        else
            $display("angle_bracket_command_parser test failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/abcp_pkg.sv
rtl/core/abcp_if.sv
rtl/core/abcp_char_decode.sv
rtl/core/abcp_value_lane.sv
rtl/core/angle_bracket_command_parser.sv
tb/abcp_frame_checker.sv
tb/angle_bracket_command_parser_tb.sv
